### design/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the reservation stations
// Station counts, operation and request codes, and cell control/status types.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int ADD_STATIONS = 4;
	localparam int MUL_STATIONS = 4;
	localparam int N_ST         = ADD_STATIONS + MUL_STATIONS;
	localparam int IDX_W        = 3;
	localparam int ADD_UNITS    = 2;
	localparam int MUL_UNITS    = 2;
	localparam int DATA_BITS    = 32;
	localparam int MAX_RESULTS  = 4;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_ADDI = 3'd3;
	localparam logic [2:0] OP_MUL  = 3'd4;
	localparam logic [2:0] OP_DIV  = 3'd5;

	localparam logic [1:0] REQ_ISSUE = 2'd0;
	localparam logic [1:0] REQ_CDB   = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] KIND_ISSUE = 2'd0;
	localparam logic [1:0] KIND_ADDER = 2'd1;
	localparam logic [1:0] KIND_MULT  = 2'd2;

	typedef logic [DATA_BITS-1:0] word_t;

	typedef struct packed {
		logic             issue_en;
		logic [2:0]       op;
		logic             a_ready;
		word_t            a_word;
		logic             b_ready;
		word_t            b_word;
		logic             cdb_en;
		logic             cdb_hit;
		logic [IDX_W-1:0] cdb_tag;
		word_t            cdb_value;
		logic             disp_en;
		logic             disp_unit;
	} cell_ctrl_t;

	typedef struct packed {
		logic       free;
		logic       dispatched;
		logic [2:0] op;
		logic       a_ready;
		word_t      a_word;
		logic       b_ready;
		word_t      b_word;
		logic       unit;
	} cell_stat_t;

	function automatic logic is_add_op(input logic [2:0] op);
		case (op) inside
			OP_ADD, OP_SUB, OP_ADDI: is_add_op = 1'b1;
			default:                 is_add_op = 1'b0;
		endcase
	endfunction

	function automatic logic is_mul_op(input logic [2:0] op);
		case (op) inside
			OP_MUL, OP_DIV: is_mul_op = 1'b1;
			default:        is_mul_op = 1'b0;
		endcase
	endfunction

endpackage

### design/tomasulo_reservation_stations.sv
// ----------------------------------------------------------------------------
// tomasulo_reservation_stations: add and mul reservation station groups
// A row of station cells with unit busy flags and a dispatch scanner.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake        | Payload
// s       | in  | tvalid/tready    | tuser request type, tdata request fields
// m       | out | tvalid/tready    | tuser result kind, tdata reply, tlast
//
// A dispatch tick walks the stations one per cycle while the output is not
// stalled, in order from station 0, and stops after the last station or once
// the fourth dispatch is found; a flush state then passes out the final
// result. No input is taken during a tick. Reset frees every station and
// every unit at once.
// ----------------------------------------------------------------------------
module tomasulo_reservation_stations (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type
	input  logic [1:0]   s_tuser,
	// op_code, src_a_ready, src_a_tag, src_a_value, src_b_ready, src_b_tag,
	// src_b_value, cdb_tag, cdb_value, zero pad
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_kind
	output logic [1:0]   m_tuser,
	// accepted, entry_index, unit_index, dispatch_op, operand_a, operand_b
	output logic [71:0]  m_tdata,
	output logic         m_tlast
);
	import trs_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             acc;
		logic [IDX_W-1:0] entry;
		logic             unit;
		logic [2:0]       op;
		word_t            a;
		word_t            b;
	} res_t;

	state_t           state_q;
	logic [IDX_W-1:0] scan_q;
	logic [2:0]       cnt_q;
	logic             pend_v_q, out_v_q, out_last_q;
	res_t             pend_q, out_q;
	logic [ADD_UNITS-1:0] add_busy_q;
	logic [MUL_UNITS-1:0] mul_busy_q;

	logic [2:0]       in_op;
	logic             in_a_rdy, in_b_rdy;
	logic [IDX_W-1:0] in_a_tag, in_b_tag, in_cdb_tag;
	word_t            in_a_val, in_b_val, in_cdb_val;

	assign in_op      = s_tdata[2:0];
	assign in_a_rdy   = s_tdata[3];
	assign in_a_tag   = s_tdata[6:4];
	assign in_a_val   = s_tdata[38:7];
	assign in_b_rdy   = s_tdata[39];
	assign in_b_tag   = s_tdata[42:40];
	assign in_b_val   = s_tdata[74:43];
	assign in_cdb_tag = s_tdata[77:75];
	assign in_cdb_val = s_tdata[109:78];

	logic out_free, accept, do_issue, do_cdb, do_tick;
	assign out_free = ~out_v_q | m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign do_issue = accept && s_tuser == REQ_ISSUE;
	assign do_cdb   = accept && s_tuser == REQ_CDB;
	assign do_tick  = accept && s_tuser == REQ_TICK;

	// Scan step: the station under the scan pointer.
	cell_stat_t stat [N_ST];
	cell_stat_t cur;
	logic       cur_add, cur_mul, add_avail, mul_avail, hit, step;
	logic       add_u, mul_u, pick_u;
	assign cur     = stat[scan_q];
	assign cur_add = is_add_op(cur.op);
	assign cur_mul = is_mul_op(cur.op);
	assign step    = (state_q == ST_SCAN) && out_free;

	always_comb begin
		add_avail = 1'b0;
		mul_avail = 1'b0;
		add_u     = 1'b0;
		mul_u     = 1'b0;
		for (int u = ADD_UNITS - 1; u >= 0; u--) begin
			if (!add_busy_q[u]) begin
				add_avail = 1'b1;
				add_u     = 1'(u);
			end
		end
		for (int u = MUL_UNITS - 1; u >= 0; u--) begin
			if (!mul_busy_q[u]) begin
				mul_avail = 1'b1;
				mul_u     = 1'(u);
			end
		end
	end

	assign hit = step && !cur.free && !cur.dispatched && cur.a_ready && cur.b_ready &&
		((cur_add && add_avail) || (cur_mul && mul_avail));
	assign pick_u = cur_add ? add_u : mul_u;

	// Station row.
	logic [N_ST:0]  take;
	logic [N_ST-1:0] win;
	logic issue_add, issue_mul;
	assign issue_add = do_issue && is_add_op(in_op);
	assign issue_mul = do_issue && is_mul_op(in_op);

	for (genvar i = 0; i < N_ST; i++) begin : g_cell
		cell_ctrl_t ctrl;
		logic       t_in;
		if (i == 0) begin : g_a
			assign t_in = issue_add;
		end else if (i == ADD_STATIONS) begin : g_m
			assign t_in = issue_mul;
		end else begin : g_n
			assign t_in = take[i];
		end
		assign ctrl = '{issue_en: do_issue, op: in_op, a_ready: in_a_rdy,
			a_word: in_a_rdy ? in_a_val : word_t'(in_a_tag),
			b_ready: in_b_rdy,
			b_word: in_b_rdy ? in_b_val : word_t'(in_b_tag),
			cdb_en: do_cdb, cdb_hit: in_cdb_tag == IDX_W'(i),
			cdb_tag: in_cdb_tag, cdb_value: in_cdb_val,
			disp_en: hit && scan_q == IDX_W'(i), disp_unit: pick_u};
		trs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.take_in  (t_in),
			.take_out (take[i+1]),
			.win      (win[i]),
			.stat     (stat[i])
		);
	end
	assign take[0] = 1'b0;

	logic [IDX_W-1:0] win_idx;
	always_comb begin
		win_idx = '0;
		for (int i = 0; i < N_ST; i++) begin
			if (win[i]) win_idx = win_idx | IDX_W'(i);
		end
	end

	res_t issue_res, disp_res;
	assign issue_res = '{kind: KIND_ISSUE, acc: |win, entry: win_idx, unit: 1'b0,
		op: OP_NONE, a: '0, b: '0};
	assign disp_res = '{kind: cur_add ? KIND_ADDER : KIND_MULT, acc: 1'b0, entry: scan_q,
		unit: pick_u, op: cur.op, a: cur.a_word, b: cur.b_word};

	// Station of the bus write, for unit release.
	cell_stat_t cdb_st;
	assign cdb_st = stat[in_cdb_tag];

	// The output register takes a new transaction in these cases only.
	logic out_load;
	assign out_load = do_issue || (hit && pend_v_q) ||
		(state_q == ST_FLUSH && out_free && pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
			add_busy_q <= '0;
			mul_busy_q <= '0;
		end else begin
			if (out_load)      out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (do_issue) begin
						out_q      <= issue_res;
						out_last_q <= 1'b1;
					end
					if (do_cdb && !cdb_st.free && cdb_st.dispatched) begin
						if (in_cdb_tag < IDX_W'(ADD_STATIONS))
							add_busy_q[cdb_st.unit] <= 1'b0;
						else
							mul_busy_q[cdb_st.unit] <= 1'b0;
					end
					if (do_tick) begin
						state_q  <= ST_SCAN;
						scan_q   <= '0;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (step) begin
						if (hit) begin
							if (cur_add) add_busy_q[pick_u] <= 1'b1;
							else         mul_busy_q[pick_u] <= 1'b1;
							// The held result is not the last one, since another follows.
							if (pend_v_q) begin
								out_q      <= pend_q;
								out_last_q <= 1'b0;
							end
							pend_q   <= disp_res;
							pend_v_q <= 1'b1;
							cnt_q    <= cnt_q + 3'd1;
						end
						if ((hit && cnt_q == 3'(MAX_RESULTS - 1)) ||
							scan_q == IDX_W'(N_ST - 1))
							state_q <= ST_FLUSH;
						else
							scan_q <= scan_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						if (pend_v_q) begin
							out_q      <= pend_q;
							out_last_q <= 1'b1;
						end
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_q.b, out_q.a, out_q.op, out_q.unit, out_q.entry, out_q.acc};

	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(win))
		else $error("more than one station taken by an issue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'(MAX_RESULTS))
		else $error("dispatch count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pend_v_q |-> cnt_q != 3'd0)
		else $error("held dispatch result without a count");
	assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> $past(cur_add) ? add_busy_q[$past(pick_u)] : mul_busy_q[$past(pick_u)])
		else $error("dispatched unit not marked busy");

endmodule

### design/trs_cell.sv
// ----------------------------------------------------------------------------
// trs_cell: one reservation station
// Holds the operation and both operands, wakes on a bus write, and passes the
// free-station search on to its neighbor.
// ----------------------------------------------------------------------------
module trs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  trs_pkg::cell_ctrl_t ctrl,
	input  logic                take_in,
	output logic                take_out,
	output logic                win,
	output trs_pkg::cell_stat_t stat
);
	import trs_pkg::*;

	logic       free_q, disp_q, a_rdy_q, b_rdy_q, unit_q;
	logic [2:0] op_q;
	word_t      a_q, b_q;
	word_t      tag_w;

	// The search for the lowest free station ripples through the cells.
	assign win      = take_in & free_q;
	assign take_out = take_in & ~free_q;
	assign tag_w    = word_t'(ctrl.cdb_tag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b1;
			disp_q  <= 1'b0;
			a_rdy_q <= 1'b0;
			b_rdy_q <= 1'b0;
		end else if (ctrl.issue_en && win) begin
			free_q  <= 1'b0;
			disp_q  <= 1'b0;
			a_rdy_q <= ctrl.a_ready;
			b_rdy_q <= ctrl.b_ready;
		end else if (ctrl.cdb_en) begin
			if (ctrl.cdb_hit) begin
				free_q <= 1'b1;
				disp_q <= 1'b0;
			end
			if (!a_rdy_q && a_q == tag_w) a_rdy_q <= 1'b1;
			if (!b_rdy_q && b_q == tag_w) b_rdy_q <= 1'b1;
		end else if (ctrl.disp_en) begin
			disp_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue_en && win) begin
			op_q <= ctrl.op;
			a_q  <= ctrl.a_word;
			b_q  <= ctrl.b_word;
		end else if (ctrl.cdb_en) begin
			if (!a_rdy_q && a_q == tag_w) a_q <= ctrl.cdb_value;
			if (!b_rdy_q && b_q == tag_w) b_q <= ctrl.cdb_value;
		end else if (ctrl.disp_en) begin
			unit_q <= ctrl.disp_unit;
		end
	end

	assign stat = '{free: free_q, dispatched: disp_q, op: op_q, a_ready: a_rdy_q,
		a_word: a_q, b_ready: b_rdy_q, b_word: b_q, unit: unit_q};

endmodule

### tb/tomasulo_reservation_stations_tb.sv
// ----------------------------------------------------------------------------
// tomasulo_reservation_stations_tb: self-checking bench for the station block
// Drives issue, bus write and dispatch tick requests over the input stream.
// A scoreboard class tracks the stations and unit flags, predicts every
// reply and dispatch, and checks the output stream transaction by transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tomasulo_reservation_stations_tb;
	import trs_pkg::*;

	typedef struct {
		logic [1:0]  req;
		logic [2:0]  op;
		logic        a_rdy;
		logic [2:0]  a_tag;
		logic [31:0] a_val;
		logic        b_rdy;
		logic [2:0]  b_tag;
		logic [31:0] b_val;
		logic [2:0]  cdb_tag;
		logic [31:0] cdb_val;
	} rs_req_t;

	typedef struct {
		logic [1:0]  kind;
		logic        acc;
		logic [2:0]  entry;
		logic        unit;
		logic [2:0]  op;
		logic [31:0] opa;
		logic [31:0] opb;
		logic        last;
	} rs_result_t;

	class station_scoreboard;
		bit          st_free [N_ST];
		bit          st_disp [N_ST];
		logic [2:0]  st_op   [N_ST];
		bit          a_rdy   [N_ST];
		logic [31:0] a_word  [N_ST];
		bit          b_rdy   [N_ST];
		logic [31:0] b_word  [N_ST];
		bit          st_unit [N_ST];
		bit          add_busy [ADD_UNITS];
		bit          mul_busy [MUL_UNITS];
		rs_result_t  pending [$];
		int          errors;

		function void clear();
			for (int i = 0; i < N_ST; i++) begin
				st_free[i] = 1; st_disp[i] = 0; st_op[i] = OP_NONE;
				a_rdy[i] = 0; a_word[i] = '0; b_rdy[i] = 0; b_word[i] = '0; st_unit[i] = 0;
			end
			foreach (add_busy[u]) add_busy[u] = 0;
			foreach (mul_busy[u]) mul_busy[u] = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void note_input(rs_req_t r);
			rs_result_t res;
			int lo, hi, pick, n, u;
			res = '{default: '0};
			if (r.req == REQ_ISSUE) begin
				lo = 0; hi = 0; pick = -1;
				if (is_add_op(r.op)) begin
					lo = 0; hi = ADD_STATIONS;
				end else if (is_mul_op(r.op)) begin
					lo = ADD_STATIONS; hi = N_ST;
				end
				for (int i = lo; i < hi; i++)
					if (pick < 0 && st_free[i]) pick = i;
				res.kind = KIND_ISSUE;
				res.last = 1;
				if (pick >= 0) begin
					st_free[pick] = 0; st_disp[pick] = 0; st_op[pick] = r.op;
					a_rdy[pick] = r.a_rdy;
					a_word[pick] = r.a_rdy ? r.a_val : 32'(r.a_tag);
					b_rdy[pick] = r.b_rdy;
					b_word[pick] = r.b_rdy ? r.b_val : 32'(r.b_tag);
					res.acc = 1;
					res.entry = pick[2:0];
				end
				pending.push_back(res);
			end else if (r.req == REQ_CDB) begin
				if (!st_free[r.cdb_tag] && st_disp[r.cdb_tag]) begin
					if (r.cdb_tag < ADD_STATIONS) add_busy[st_unit[r.cdb_tag]] = 0;
					else mul_busy[st_unit[r.cdb_tag]] = 0;
				end
				st_free[r.cdb_tag] = 1;
				st_disp[r.cdb_tag] = 0;
				for (int i = 0; i < N_ST; i++) begin
					if (!a_rdy[i] && a_word[i] == 32'(r.cdb_tag)) begin
						a_rdy[i] = 1; a_word[i] = r.cdb_val;
					end
					if (!b_rdy[i] && b_word[i] == 32'(r.cdb_tag)) begin
						b_rdy[i] = 1; b_word[i] = r.cdb_val;
					end
				end
			end else if (r.req == REQ_TICK) begin
				n = 0;
				for (int i = 0; i < N_ST && n < MAX_RESULTS; i++) begin
					if (st_free[i] || st_disp[i] || !a_rdy[i] || !b_rdy[i]) continue;
					u = -1;
					if (is_add_op(st_op[i])) begin
						for (int k = ADD_UNITS - 1; k >= 0; k--) if (!add_busy[k]) u = k;
						if (u < 0) continue;
						add_busy[u] = 1;
						res.kind = KIND_ADDER;
					end else if (is_mul_op(st_op[i])) begin
						for (int k = MUL_UNITS - 1; k >= 0; k--) if (!mul_busy[k]) u = k;
						if (u < 0) continue;
						mul_busy[u] = 1;
						res.kind = KIND_MULT;
					end else begin
						continue;
					end
					st_unit[i] = u[0];
					st_disp[i] = 1;
					res.acc = 0; res.entry = i[2:0]; res.unit = u[0]; res.op = st_op[i];
					res.opa = a_word[i]; res.opb = b_word[i]; res.last = 0;
					pending.push_back(res);
					n++;
				end
				if (n > 0) pending[pending.size() - 1].last = 1;
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [71:0] data, logic last);
			rs_result_t got, exp;
			got.kind = kind; got.acc = data[0]; got.entry = data[3:1]; got.unit = data[4];
			got.op = data[7:5]; got.opa = data[39:8]; got.opb = data[71:40]; got.last = last;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result kind=%0d data=%h", $time, kind, data);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind) begin
				$display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind); errors++;
			end
			if (got.acc !== exp.acc) begin
				$display("%0t: accepted exp %0d got %0d", $time, exp.acc, got.acc); errors++;
			end
			if (got.entry !== exp.entry) begin
				$display("%0t: entry exp %0d got %0d", $time, exp.entry, got.entry); errors++;
			end
			if (got.unit !== exp.unit) begin
				$display("%0t: unit exp %0d got %0d", $time, exp.unit, got.unit); errors++;
			end
			if (got.op !== exp.op) begin
				$display("%0t: op exp %0d got %0d", $time, exp.op, got.op); errors++;
			end
			if (got.opa !== exp.opa) begin
				$display("%0t: operand_a exp %h got %h", $time, exp.opa, got.opa); errors++;
			end
			if (got.opb !== exp.opb) begin
				$display("%0t: operand_b exp %h got %h", $time, exp.opb, got.opb); errors++;
			end
			if (got.last !== exp.last) begin
				$display("%0t: last exp %0d got %0d", $time, exp.last, got.last); errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [1:0]   s_tuser = '0;
	logic [111:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [1:0]   m_tuser;
	logic [71:0]  m_tdata;
	logic         m_tlast;

	station_scoreboard sb;
	bit quiet = 0;
	bit hold_request = 0;

	tomasulo_reservation_stations u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off to back the block up.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 0;
				repeat (80) @(negedge clk);
				hold_request = 0;
				m_tready <= 1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 11);
				m_tready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);

	task automatic send_req(rs_req_t r);
		int n;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			s_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= r.req;
		s_tdata <= {2'b00, r.cdb_val, r.cdb_tag, r.b_val, r.b_tag, r.b_rdy,
			r.a_val, r.a_tag, r.a_rdy, r.op};
		do @(posedge clk); while (!s_tready);
		sb.note_input(r);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic rs_req_t mk(logic [1:0] req, logic [2:0] op,
			logic ar, logic [2:0] at, logic [31:0] av,
			logic br, logic [2:0] bt, logic [31:0] bv,
			logic [2:0] ct, logic [31:0] cv);
		rs_req_t r;
		r.req = req; r.op = op; r.a_rdy = ar; r.a_tag = at; r.a_val = av;
		r.b_rdy = br; r.b_tag = bt; r.b_val = bv; r.cdb_tag = ct; r.cdb_val = cv;
		return r;
	endfunction

	function automatic rs_req_t rand_req();
		rs_req_t r;
		int sel, cnt;
		logic [2:0] list [$];
		r = mk(REQ_ISSUE, OP_NONE, 1'($urandom), 3'($urandom), rand_word(),
			1'($urandom), 3'($urandom), rand_word(), 3'($urandom), rand_word());
		sel = $urandom_range(0, 99);
		if (sel < 42) begin
			r.req = REQ_ISSUE;
			r.op = (sel < 2) ? 3'($urandom_range(6, 7)) : (sel < 3) ? OP_NONE
				: 3'($urandom_range(OP_ADD, OP_DIV));
		end else if (sel < 66) begin
			r.req = REQ_TICK;
		end else if (sel < 97) begin
			r.req = REQ_CDB;
			// Mostly broadcast for a station that is in flight, as a real unit would.
			for (int i = 0; i < N_ST; i++)
				if (!sb.st_free[i] && sb.st_disp[i]) list.push_back(i[2:0]);
			cnt = list.size();
			if (cnt > 0 && $urandom_range(0, 4) != 0)
				r.cdb_tag = list[$urandom_range(0, cnt - 1)];
		end else begin
			r.req = 2'd3;
		end
		return r;
	endfunction

	initial begin
		int waited;
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: every operation, extremes of the operand fields, a full add group,
		// unit exhaustion, wakeup through a bus write, and ignored requests.
		send_req(mk(REQ_ISSUE, OP_ADD, 1, 0, 32'h0, 1, 7, 32'hFFFF_FFFF, 0, 0));
		send_req(mk(REQ_ISSUE, OP_SUB, 1, 7, 32'hFFFF_FFFF, 1, 0, 32'h0, 0, 0));
		send_req(mk(REQ_ISSUE, OP_ADDI, 0, 7, 32'h0, 1, 0, 32'h1234_5678, 0, 0));
		send_req(mk(REQ_ISSUE, OP_ADD, 1, 0, 32'hAAAA_5555, 0, 4, 32'h0, 0, 0));
		send_req(mk(REQ_ISSUE, OP_ADD, 1, 0, 32'h1, 1, 0, 32'h2, 0, 0));
		send_req(mk(REQ_ISSUE, OP_MUL, 1, 0, 32'h5555_AAAA, 1, 0, 32'h8000_0000, 0, 0));
		send_req(mk(REQ_ISSUE, OP_DIV, 1, 0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 0, 0));
		send_req(mk(REQ_ISSUE, OP_MUL, 1, 0, 32'h7, 1, 0, 32'h9, 0, 0));
		send_req(mk(REQ_ISSUE, OP_NONE, 1, 0, 32'h0, 1, 0, 32'h0, 0, 0));
		send_req(mk(REQ_ISSUE, 3'd6, 1, 0, 32'h0, 1, 0, 32'h0, 0, 0));
		send_req(mk(REQ_ISSUE, 3'd7, 1, 0, 32'h0, 1, 0, 32'h0, 0, 0));
		send_req(mk(REQ_TICK, OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk(REQ_TICK, OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk(REQ_CDB, OP_NONE, 0, 0, 0, 0, 0, 0, 0, 32'hDEAD_BEEF));
		send_req(mk(REQ_CDB, OP_NONE, 0, 0, 0, 0, 0, 0, 7, 32'hFFFF_FFFF));
		send_req(mk(REQ_CDB, OP_NONE, 0, 0, 0, 0, 0, 0, 4, 32'h0));
		send_req(mk(REQ_TICK, OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk(2'd3, OP_ADD, 1, 0, 32'h1, 1, 0, 32'h1, 0, 0));
		send_req(mk(REQ_CDB, OP_NONE, 0, 0, 0, 0, 0, 0, 5, 32'h0));
		send_req(mk(REQ_CDB, OP_NONE, 0, 0, 0, 0, 0, 0, 1, 32'h0));
		send_req(mk(REQ_ISSUE, OP_MUL, 1, 0, 32'h3, 1, 0, 32'h4, 0, 0));
		send_req(mk(REQ_TICK, OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int k = 0; k < 390; k++) begin
			if (k == 120) hold_request = 1;
			if (k == 330) quiet = 1;
			send_req(rand_req());
		end
		@(negedge clk);
		s_tvalid <= 0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

### sim.f
design/trs_pkg.sv
design/trs_cell.sv
design/tomasulo_reservation_stations.sv
tb/tomasulo_reservation_stations_tb.sv
